### hw/rtl/huffman_tree_walk_decoder_core_macros.svh
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HTWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htwd check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define HTWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htwd check failed");

`endif

### hw/rtl/htwd_pkg.sv
`default_nettype none

package htwd_pkg;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 2;
    localparam int SYM_W     = 8;

    // commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SYMBOL   = 2'd0;
    localparam logic [1:0] KIND_NULLPATH = 2'd1;
    localparam logic [1:0] KIND_LOADERR  = 2'd2;
    localparam logic [1:0] KIND_NOTREADY = 2'd3;

    // serialized null child
    localparam logic [SYM_W-1:0] TOKEN_NULL = 8'hFF;

endpackage

`default_nettype wire

### hw/rtl/huffman_tree_walk_decoder_core.sv
`default_nettype none

// Huffman tree-walk decoder. A clear command (tuser 0) starts a new tree; load commands
// (tuser 1) deliver the tree in preorder one token at a time, -1 marking a null child;
// decode commands (tuser 2) deliver one code bit each and a symbol comes out whenever the
// walk reaches a leaf. Each item is registered at the transfer while the node and stack
// memories are read, and it is executed from the registered read data once the output
// register is free, after which the next item is taken. A finished result sits in the
// output register, so the next item is taken while it waits; execution holds whenever
// the output register is full and not being taken. Errors are sticky until the next clear.
// The node memories need no clearing pass after reset.
module huffman_tree_walk_decoder_core #(
    parameter int MAX_NODES = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] token, [8] code_bit, rest zero
    input  wire logic [htwd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  wire logic [htwd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] symbol
    output logic [htwd_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] kind
    output logic [htwd_pkg::M_TUSER_W-1:0]      m_tuser
);

    import htwd_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] NULL_CHILD = CW'(MAX_NODES);

    typedef enum logic [1:0] {
        PH_BUILD,
        PH_READY,
        PH_ERROR
    } phase_t;

    // node and stack memories
    logic [CW-1:0]    left_mem  [MAX_NODES];
    logic [CW-1:0]    right_mem [MAX_NODES];
    logic [SYM_W-1:0] sym_mem   [MAX_NODES];
    logic [NW-1:0]    stack_mem [MAX_NODES];

    logic [CW-1:0]    rd_left_reg;
    logic [CW-1:0]    rd_right_reg;
    logic [SYM_W-1:0] rd_sym_reg;
    logic [NW-1:0]    rd_stack_reg;

    // control state
    phase_t        phase_reg, phase_next;
    logic          in_valid_reg, in_valid_next;
    logic          root_valid_reg, root_valid_next;
    logic [CW-1:0] stack_depth_reg, stack_depth_next;
    logic [CW-1:0] node_total_reg, node_total_next;
    logic          fill_root_reg, fill_root_next;
    logic          m_valid_reg, m_valid_next;

    // payload state
    logic [1:0]       in_cmd_reg;
    logic [SYM_W-1:0] in_token_reg;
    logic             in_bit_reg;
    logic [NW-1:0]    fill_node_reg, fill_node_next;
    logic             fill_side_reg, fill_side_next;
    logic [CW-1:0]    cur_left_reg, cur_left_next;
    logic [CW-1:0]    cur_right_reg, cur_right_next;
    logic [CW-1:0]    root_left_reg, root_left_next;
    logic [CW-1:0]    root_right_reg, root_right_next;
    logic [1:0]       m_kind_reg, m_kind_next;
    logic [SYM_W-1:0] m_sym_reg, m_sym_next;

    logic          s_fire;
    logic          out_free;
    logic          exec_fire;
    logic [NW-1:0] rd_node;
    logic [CW-1:0] stack_dec;
    logic [NW-1:0] stack_top_idx;
    logic [CW-1:0] step_child;

    logic          slot_write;
    logic [CW-1:0] slot_child;
    logic          left_we;
    logic          right_we;
    logic          push_we;
    logic          cur_to_root;
    logic          cur_to_read;

    assign s_tready  = !in_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign exec_fire = in_valid_reg && out_free;

    assign rd_node       = s_tdata[8] ? cur_right_reg[NW-1:0] : cur_left_reg[NW-1:0];
    assign stack_dec     = stack_depth_reg - CW'(1);
    assign stack_top_idx = stack_dec[NW-1:0];
    assign step_child    = in_bit_reg ? cur_right_reg : cur_left_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sym_reg;
    assign m_tuser  = m_kind_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        in_valid_next    = in_valid_reg;
        root_valid_next  = root_valid_reg;
        stack_depth_next = stack_depth_reg;
        node_total_next  = node_total_reg;
        fill_root_next   = fill_root_reg;
        fill_node_next   = fill_node_reg;
        fill_side_next   = fill_side_reg;
        root_left_next   = root_left_reg;
        root_right_next  = root_right_reg;
        cur_left_next    = cur_left_reg;
        cur_right_next   = cur_right_reg;
        m_valid_next     = m_valid_reg;
        m_kind_next      = m_kind_reg;
        m_sym_next       = m_sym_reg;
        slot_write       = 1'b0;
        slot_child       = NULL_CHILD;
        left_we          = 1'b0;
        right_we         = 1'b0;
        push_we          = 1'b0;
        cur_to_root      = 1'b0;
        cur_to_read      = 1'b0;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end

        if (exec_fire)
        begin
            in_valid_next = 1'b0;
            case (in_cmd_reg)
                CMD_CLEAR:
                begin
                    stack_depth_next = '0;
                    node_total_next  = '0;
                    fill_root_next   = 1'b1;
                    root_valid_next  = 1'b0;
                    phase_next       = PH_BUILD;
                end
                CMD_LOAD:
                begin
                    case (phase_reg)
                        PH_BUILD:
                        begin
                            if (in_token_reg == TOKEN_NULL)
                            begin
                                slot_write = 1'b1;
                                slot_child = NULL_CHILD;
                                if (stack_depth_reg == '0)
                                begin
                                    phase_next  = PH_READY;
                                    cur_to_root = 1'b1;
                                end
                                else
                                begin
                                    // pop the node whose right child comes next
                                    stack_depth_next = stack_dec;
                                    fill_root_next   = 1'b0;
                                    fill_node_next   = rd_stack_reg;
                                    fill_side_next   = 1'b1;
                                end
                            end
                            else if (node_total_reg >= CW'(MAX_NODES) ||
                                     stack_depth_reg >= CW'(MAX_NODES))
                            begin
                                phase_next   = PH_ERROR;
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_LOADERR;
                                m_sym_next   = '0;
                            end
                            else
                            begin
                                slot_write       = 1'b1;
                                slot_child       = node_total_reg;
                                push_we          = 1'b1;
                                stack_depth_next = stack_depth_reg + CW'(1);
                                node_total_next  = node_total_reg + CW'(1);
                                fill_root_next   = 1'b0;
                                fill_node_next   = node_total_reg[NW-1:0];
                                fill_side_next   = 1'b0;
                            end
                        end
                        PH_READY:
                        begin
                            phase_next   = PH_ERROR;
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_LOADERR;
                            m_sym_next   = '0;
                        end
                        default:
                        begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_LOADERR;
                            m_sym_next   = '0;
                        end
                    endcase
                end
                CMD_DECODE:
                begin
                    case (phase_reg)
                        PH_READY:
                        begin
                            if (!root_valid_reg || step_child == NULL_CHILD)
                            begin
                                phase_next   = PH_ERROR;
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_NULLPATH;
                                m_sym_next   = '0;
                            end
                            else if (rd_left_reg == NULL_CHILD && rd_right_reg == NULL_CHILD)
                            begin
                                m_valid_next = 1'b1;
                                m_kind_next  = KIND_SYMBOL;
                                m_sym_next   = rd_sym_reg;
                                cur_to_root  = 1'b1;
                            end
                            else
                            begin
                                cur_to_read = 1'b1;
                            end
                        end
                        PH_BUILD:
                        begin
                            phase_next   = PH_ERROR;
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_NOTREADY;
                            m_sym_next   = '0;
                        end
                        default:
                        begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_NOTREADY;
                            m_sym_next   = '0;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        // fill the pending slot: the root flag or a child field of a built node
        if (slot_write)
        begin
            if (fill_root_reg)
            begin
                root_valid_next = (slot_child != NULL_CHILD);
            end
            else
            begin
                left_we  = !fill_side_reg;
                right_we = fill_side_reg;
                if (fill_node_reg == '0)
                begin
                    if (fill_side_reg)
                    begin
                        root_right_next = slot_child;
                    end
                    else
                    begin
                        root_left_next = slot_child;
                    end
                end
            end
        end

        // children of the current walk node are kept in registers
        if (cur_to_root)
        begin
            cur_left_next  = root_left_next;
            cur_right_next = root_right_next;
        end
        else if (cur_to_read)
        begin
            cur_left_next  = rd_left_reg;
            cur_right_next = rd_right_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BUILD;
            in_valid_reg    <= 1'b0;
            root_valid_reg  <= 1'b0;
            stack_depth_reg <= '0;
            node_total_reg  <= '0;
            fill_root_reg   <= 1'b1;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            in_valid_reg    <= in_valid_next;
            root_valid_reg  <= root_valid_next;
            stack_depth_reg <= stack_depth_next;
            node_total_reg  <= node_total_next;
            fill_root_reg   <= fill_root_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_cmd_reg   <= s_tuser;
            in_token_reg <= s_tdata[7:0];
            in_bit_reg   <= s_tdata[8];
        end
        fill_node_reg  <= fill_node_next;
        fill_side_reg  <= fill_side_next;
        cur_left_reg   <= cur_left_next;
        cur_right_reg  <= cur_right_next;
        root_left_reg  <= root_left_next;
        root_right_reg <= root_right_next;
        m_kind_reg     <= m_kind_next;
        m_sym_reg      <= m_sym_next;
    end

    // memories: read at the transfer, written when the item executes
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            rd_left_reg  <= left_mem[rd_node];
            rd_right_reg <= right_mem[rd_node];
            rd_sym_reg   <= sym_mem[rd_node];
            rd_stack_reg <= stack_mem[stack_top_idx];
        end
        if (left_we)
        begin
            left_mem[fill_node_reg] <= slot_child;
        end
        if (right_we)
        begin
            right_mem[fill_node_reg] <= slot_child;
        end
        if (push_we)
        begin
            sym_mem[node_total_reg[NW-1:0]]    <= in_token_reg;
            stack_mem[stack_depth_reg[NW-1:0]] <= node_total_reg[NW-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/htwd_checker.sv
`default_nettype none

`include "huffman_tree_walk_decoder_core_macros.svh"

module htwd_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [htwd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [htwd_pkg::M_TUSER_W-1:0] m_tuser
);

    import htwd_pkg::*;

    // a stalled result holds
    `HTWD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // error results carry a zero symbol
    `HTWD_ASSERT_NOW(a_err_sym_zero, m_tvalid && m_tuser != KIND_SYMBOL, m_tdata == '0)

    // an item occupies the block for its execute cycle
    `HTWD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // a fresh result comes from an earlier transfer, through the input and output registers
    `HTWD_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind huffman_tree_walk_decoder_core htwd_checker u_htwd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
